/* src/wsdf_pkg.sv */
// Shared types, constants and the opcode decoder of the WebSocket frame deframer.
package wsdf_pkg;

   localparam int LEN_BITS_DEFAULT = 64;

   typedef logic [2:0] ftype_type;

   localparam ftype_type TYPE_CONT    = 3'd0;
   localparam ftype_type TYPE_TEXT    = 3'd1;
   localparam ftype_type TYPE_BINARY  = 3'd2;
   localparam ftype_type TYPE_PING    = 3'd3;
   localparam ftype_type TYPE_PONG    = 3'd4;
   localparam ftype_type TYPE_CLOSE   = 3'd5;
   localparam ftype_type TYPE_INVALID = 3'd6;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'ha;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   localparam logic [2:0] PH_HDR1 = 3'd0;
   localparam logic [2:0] PH_HDR2 = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_MASK = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;

   function automatic ftype_type map_opcode(input logic [3:0] op);
      ftype_type t;
      unique case (op)
         OP_CONT:   t = TYPE_CONT;
         OP_TEXT:   t = TYPE_TEXT;
         OP_BINARY: t = TYPE_BINARY;
         OP_CLOSE:  t = TYPE_CLOSE;
         OP_PING:   t = TYPE_PING;
         OP_PONG:   t = TYPE_PONG;
         default:   t = TYPE_INVALID;
      endcase
      return t;
   endfunction

endpackage

/* src/websocket_frame_deframer.sv */
// WebSocket frame deframer: byte-wide header parser, unmasking and result register.
//
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid / req_stall | req_in_byte
//  rsp_    | out       | rsp_valid / rsp_stall | rsp_payload_byte, rsp_payload_valid,
//          |           |                       | rsp_frame_type, rsp_final_fragment,
//          |           |                       | rsp_frame_end
//
// A request is taken every cycle in which the result register is empty or is
// being taken; its result, if any, shows in the result register on the next
// cycle. Header, extended length and mask key bytes give no result, but the last
// of them in an empty frame gives a bare end marker.
// Synchronous reset returns the parser to the first header byte.
module websocket_frame_deframer #(
   parameter int LEN_BITS = wsdf_pkg::LEN_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_payload_byte,
   output logic                rsp_payload_valid,
   output wsdf_pkg::ftype_type rsp_frame_type,
   output logic                rsp_final_fragment,
   output logic                rsp_frame_end
);
   import wsdf_pkg::*;

   logic [2:0]          phase_ff, phase_in;
   logic [3:0]          len_left_ff, len_left_in;
   logic [LEN_BITS-1:0] remain_ff, remain_in;
   logic [31:0]         key_ff, key_in;
   logic [2:0]          key_left_ff, key_left_in;
   logic [1:0]          pos_ff, pos_in;
   ftype_type           type_ff, type_in;
   logic                fin_ff, fin_in;
   logic                masked_ff, masked_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          data_ff;
   logic                dvalid_ff;
   ftype_type           otype_ff;
   logic                ofin_ff;
   logic                end_ff;

   logic                accept;
   logic                emit;
   logic [7:0]          emit_data;
   logic                emit_dvalid;
   logic                emit_end;
   logic [6:0]          len7;
   logic [LEN_BITS-1:0] remain_dec;
   logic [7:0]          key_byte;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign len7      = req_in_byte[6:0];
   assign remain_dec = remain_ff - LEN_BITS'(1);

   always_comb begin
      unique case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      len_left_in = len_left_ff;
      remain_in   = remain_ff;
      key_in      = key_ff;
      key_left_in = key_left_ff;
      pos_in      = pos_ff;
      type_in     = type_ff;
      fin_in      = fin_ff;
      masked_in   = masked_ff;
      emit        = 1'b0;
      emit_data   = 8'h00;
      emit_dvalid = 1'b0;
      emit_end    = 1'b0;
      unique case (phase_ff)
         PH_HDR1: begin
            fin_in   = req_in_byte[7];
            type_in  = map_opcode(req_in_byte[3:0]);
            phase_in = PH_HDR2;
         end
         PH_HDR2: begin
            masked_in = req_in_byte[7];
            key_in    = 32'h0;
            if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
               len_left_in = (len7 == LEN7_EXT64) ? EXT64_BYTES : EXT16_BYTES;
               remain_in   = '0;
               phase_in    = PH_LEN;
            end else begin
               remain_in = LEN_BITS'(len7);
               if (req_in_byte[7]) begin
                  key_left_in = KEY_BYTES;
                  phase_in    = PH_MASK;
               end else begin
                  pos_in = 2'd0;
                  if (len7 == 7'd0) begin
                     // empty frame: close it out with a bare end marker
                     emit     = 1'b1;
                     emit_end = 1'b1;
                     phase_in = PH_HDR1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
         end
         PH_LEN: begin
            remain_in   = {remain_ff[LEN_BITS-9:0], req_in_byte};
            len_left_in = len_left_ff - 4'd1;
            if (len_left_ff == 4'd1) begin
               if (masked_ff) begin
                  key_left_in = KEY_BYTES;
                  phase_in    = PH_MASK;
               end else begin
                  pos_in = 2'd0;
                  if ({remain_ff[LEN_BITS-9:0], req_in_byte} == '0) begin
                     emit     = 1'b1;
                     emit_end = 1'b1;
                     phase_in = PH_HDR1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
         end
         PH_MASK: begin
            key_in      = {key_ff[23:0], req_in_byte};
            key_left_in = key_left_ff - 3'd1;
            if (key_left_ff == 3'd1) begin
               pos_in = 2'd0;
               if (remain_ff == '0) begin
                  emit     = 1'b1;
                  emit_end = 1'b1;
                  phase_in = PH_HDR1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            emit        = 1'b1;
            emit_dvalid = 1'b1;
            emit_data   = masked_ff ? (req_in_byte ^ key_byte) : req_in_byte;
            pos_in      = pos_ff + 2'd1;
            remain_in   = remain_dec;
            emit_end    = (remain_dec == '0);
            if (remain_dec == '0) begin
               phase_in = PH_HDR1;
            end
         end
         default: begin
            phase_in = PH_HDR1;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR1;
         len_left_ff  <= 4'd0;
         remain_ff    <= '0;
         key_ff       <= 32'h0;
         key_left_ff  <= 3'd0;
         pos_ff       <= 2'd0;
         type_ff      <= TYPE_CONT;
         fin_ff       <= 1'b0;
         masked_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff    <= phase_in;
            len_left_ff <= len_left_in;
            remain_ff   <= remain_in;
            key_ff      <= key_in;
            key_left_ff <= key_left_in;
            pos_ff      <= pos_in;
            type_ff     <= type_in;
            fin_ff      <= fin_in;
            masked_ff   <= masked_in;
         end
      end
   end

   // load the result register only when the request yields a result
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         data_ff   <= emit_data;
         dvalid_ff <= emit_dvalid;
         otype_ff  <= type_ff;
         ofin_ff   <= fin_ff;
         end_ff    <= emit_end;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = data_ff;
   assign rsp_payload_valid  = dvalid_ff;
   assign rsp_frame_type     = otype_ff;
   assign rsp_final_fragment = ofin_ff;
   assign rsp_frame_end      = end_ff;

endmodule
